[rtl/core/sll_pkg.sv]
`timescale 1ns / 1ps

package sll_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int STEP_W     = SLOT_W + 1;
  localparam int MODE_W     = 2;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 4;

  localparam logic [SLOT_W-1:0] FREE_HEAD = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] LIST_HEAD = SLOT_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_PAST_END  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_INS_STEP,
    DP_INS_TAKE,
    DP_INS1,
    DP_INS2,
    DP_INS3,
    DP_FIND_RD,
    DP_FIND_NEXT,
    DP_UPD,
    DP_DEL1,
    DP_DEL2,
    DP_DEL3
  } dp_op_t;

  typedef enum logic [1:0] {
    RS_HEAD,
    RS_FREE,
    RS_CUR,
    RS_AT
  } rsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_INS_WALK,
    ST_INS_TAKE,
    ST_INS1,
    ST_INS2,
    ST_INS3,
    ST_FIND_CHK,
    ST_FIND_CMP,
    ST_DEL1,
    ST_DEL2,
    ST_DEL3,
    ST_FIN
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    rsel_t   rsel;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  cur_zero;
    logic  steps_done;
    logic  match;
    logic  pos_reached;
    logic  link_zero;
    logic  out_free;
  } dp_stat_t;

endpackage

[rtl/core/static_linked_list_engine_top.sv]
`timescale 1ns / 1ps

// Linked list of 32-bit values kept in a fixed table of slots, with slot 0
// heading the free list and slot 1 the dummy head of the data list; after
// reset the list is empty. Each item is insert, delete, search or update and
// gives exactly one result item with a status and a slot. One item is in
// work at a time, and the next is taken as soon as the result is registered.
// The link table is read once per cycle, so the time per item follows the
// list walk: insert steps through the list up to the position, and delete,
// search and update check and compare each node visited in two states,
// ST_FIND_CHK and ST_FIND_CMP (the value store has a registered read).

module static_linked_list_engine_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sll_pkg::MODE_W-1:0]           in_mode,
  input  logic [sll_pkg::POS_W-1:0]            in_position,
  input  logic signed [sll_pkg::VALUE_W-1:0]   in_value,
  input  logic signed [sll_pkg::VALUE_W-1:0]   in_new_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sll_pkg::STATUS_W-1:0]         out_status,
  output logic [sll_pkg::OUT_SLOT_W-1:0]       out_slot
);
  import sll_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sll_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_slot     (out_slot)
  );

endmodule

[rtl/core/sll_ctrl.sv]
`timescale 1ns / 1ps

module sll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sll_pkg::dp_stat_t stat,
  output sll_pkg::dp_cmd_t  cmd
);
  import sll_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      res_status_r <= STAT_OK;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    cmd.op         = DP_NOP;
    cmd.rsel       = RS_HEAD;
    cmd.res_load   = 1'b0;
    cmd.res_status = res_status_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.rsel = RS_HEAD;
        cmd.op   = DP_START;
        if (stat.mode == MODE_INSERT) begin
          state_nxt = ST_INS_WALK;
        end else begin
          state_nxt = ST_FIND_CHK;
        end
      end
      ST_INS_WALK: begin
        cmd.rsel = RS_AT;
        if (stat.pos_reached) begin
          state_nxt = ST_INS_TAKE;
        end else if (stat.link_zero) begin
          res_status_nxt = STAT_PAST_END;
          state_nxt      = ST_FIN;
        end else begin
          cmd.op = DP_INS_STEP;
        end
      end
      ST_INS_TAKE: begin
        cmd.rsel = RS_FREE;
        if (stat.link_zero) begin
          res_status_nxt = STAT_FULL;
          state_nxt      = ST_FIN;
        end else begin
          cmd.op    = DP_INS_TAKE;
          state_nxt = ST_INS1;
        end
      end
      ST_INS1: begin
        cmd.rsel  = RS_CUR;
        cmd.op    = DP_INS1;
        state_nxt = ST_INS2;
      end
      ST_INS2: begin
        cmd.rsel  = RS_AT;
        cmd.op    = DP_INS2;
        state_nxt = ST_INS3;
      end
      ST_INS3: begin
        cmd.op         = DP_INS3;
        res_status_nxt = STAT_OK;
        state_nxt      = ST_FIN;
      end
      ST_FIND_CHK: begin
        if (stat.cur_zero || stat.steps_done) begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = ST_FIN;
        end else begin
          cmd.op    = DP_FIND_RD;
          state_nxt = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        cmd.rsel = RS_CUR;
        if (!stat.match) begin
          cmd.op    = DP_FIND_NEXT;
          state_nxt = ST_FIND_CHK;
        end else if (stat.mode == MODE_DELETE) begin
          state_nxt = ST_DEL1;
        end else begin
          if (stat.mode == MODE_UPDATE) begin
            cmd.op = DP_UPD;
          end
          res_status_nxt = STAT_OK;
          state_nxt      = ST_FIN;
        end
      end
      ST_DEL1: begin
        cmd.rsel  = RS_CUR;
        cmd.op    = DP_DEL1;
        state_nxt = ST_DEL2;
      end
      ST_DEL2: begin
        cmd.rsel  = RS_FREE;
        cmd.op    = DP_DEL2;
        state_nxt = ST_DEL3;
      end
      ST_DEL3: begin
        cmd.op         = DP_DEL3;
        res_status_nxt = STAT_OK;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/sll_dp.sv]
`timescale 1ns / 1ps

module sll_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sll_pkg::dp_cmd_t                       cmd,
  output sll_pkg::dp_stat_t                      stat,
  input  logic [sll_pkg::MODE_W-1:0]             in_mode,
  input  logic [sll_pkg::POS_W-1:0]              in_position,
  input  logic signed [sll_pkg::VALUE_W-1:0]     in_value,
  input  logic signed [sll_pkg::VALUE_W-1:0]     in_new_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sll_pkg::STATUS_W-1:0]           out_status,
  output logic [sll_pkg::OUT_SLOT_W-1:0]         out_slot
);
  import sll_pkg::*;

  logic [SLOT_W-1:0]         links_r [SLOTS];
  logic signed [VALUE_W-1:0] values_mem [SLOTS];

  mode_t                     mode_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] new_value_r;
  logic [SLOT_W-1:0]         cur_r;
  logic [SLOT_W-1:0]         prev_r;
  logic [SLOT_W-1:0]         at_r;
  logic [STEP_W-1:0]         steps_r;
  logic [POS_W-1:0]          idx_r;
  logic signed [VALUE_W-1:0] val_rd_r;
  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [OUT_SLOT_W-1:0]     out_slot_r;

  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] link_rd;

  always_comb begin
    unique case (cmd.rsel)
      RS_HEAD: rd_addr = LIST_HEAD;
      RS_FREE: rd_addr = FREE_HEAD;
      RS_CUR:  rd_addr = cur_r;
      RS_AT:   rd_addr = at_r;
      default: rd_addr = LIST_HEAD;
    endcase
  end

  assign link_rd = links_r[rd_addr];

  assign stat.mode        = mode_r;
  assign stat.cur_zero    = (cur_r == '0);
  assign stat.steps_done  = (steps_r == STEP_W'(SLOTS));
  assign stat.match       = (val_rd_r == value_r);
  assign stat.pos_reached = (idx_r >= pos_r);
  assign stat.link_zero   = (link_rd == '0);
  assign stat.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (i + 1 < SLOTS) begin
          links_r[i] <= SLOT_W'(i + 1);
        end else begin
          links_r[i] <= '0;
        end
      end
      links_r[FREE_HEAD] <= SLOT_W'(2);
      links_r[LIST_HEAD] <= '0;
    end else begin
      unique case (cmd.op)
        DP_DEL1: links_r[prev_r]    <= link_rd;
        DP_DEL2: links_r[cur_r]     <= link_rd;
        DP_DEL3: links_r[FREE_HEAD] <= cur_r;
        DP_INS1: links_r[FREE_HEAD] <= link_rd;
        DP_INS2: links_r[cur_r]     <= link_rd;
        DP_INS3: links_r[at_r]      <= cur_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_INS1) begin
      values_mem[cur_r] <= value_r;
    end else if (cmd.op == DP_UPD) begin
      values_mem[cur_r] <= new_value_r;
    end
    if (cmd.op == DP_FIND_RD) begin
      val_rd_r <= values_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        mode_r      <= mode_t'(in_mode);
        pos_r       <= in_position;
        value_r     <= in_value;
        new_value_r <= in_new_value;
      end
      DP_START: begin
        prev_r  <= LIST_HEAD;
        cur_r   <= link_rd;
        steps_r <= '0;
        at_r    <= LIST_HEAD;
        idx_r   <= POS_W'(1);
      end
      DP_INS_STEP: begin
        at_r  <= link_rd;
        idx_r <= idx_r + POS_W'(1);
      end
      DP_INS_TAKE: begin
        cur_r <= link_rd;
      end
      DP_FIND_NEXT: begin
        prev_r  <= cur_r;
        cur_r   <= link_rd;
        steps_r <= steps_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_slot_r   <= (cmd.res_status == STAT_OK) ? OUT_SLOT_W'(cur_r) : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule
